>>> design/gcrb_pkg.sv
// Shared constants and opcodes for the greedy capacitated route builder.
`default_nettype none
package gcrb_pkg;
	localparam int DEF_MAX_NODES      = 64;
	localparam int DEF_MAX_VEHICLES   = 8;
	localparam int DEF_NEIGHBOR_SLOTS = 8;
	localparam int DEF_DIST_BITS      = 16;

	localparam int OPCODE_W   = 3;
	localparam int INDEX_W    = 6;
	localparam int VALUE_W    = 20;
	localparam int DEMAND_W   = 16;
	localparam int CAP_W      = 20;
	localparam int NB_ID_W    = 6;
	localparam int VEHICLE_W  = 3;
	localparam int VCOUNT_W   = 4;
	localparam int NCOUNT_W   = 7;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	localparam logic [OPCODE_W-1:0] OP_DEMAND   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_CAPACITY = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_DISTANCE = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_NB_ENTRY = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_NB_COUNT = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_START    = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_VEHICLE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT    = 1'd1;
endpackage
`default_nettype wire

>>> design/gcrb_if.sv
// Request and result channel interfaces with valid and ready.
`default_nettype none
interface gcrb_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [gcrb_pkg::OPCODE_W-1:0]  opcode;
	logic [gcrb_pkg::INDEX_W-1:0]   row_index;
	logic [gcrb_pkg::INDEX_W-1:0]   col_index;
	logic [gcrb_pkg::VALUE_W-1:0]   load_value;
	modport source (output valid, opcode, row_index, col_index, load_value, input ready);
	modport sink (input valid, opcode, row_index, col_index, load_value, output ready);
endinterface

interface gcrb_route_if;
	logic                           valid;
	logic                           ready;
	logic [gcrb_pkg::VEHICLE_W-1:0] vehicle;
	logic [gcrb_pkg::INDEX_W-1:0]   client;
	logic                           is_assignment;
	logic                           last;
	modport source (output valid, vehicle, client, is_assignment, last, input ready);
	modport sink (input valid, vehicle, client, is_assignment, last, output ready);
endinterface
`default_nettype wire

>>> design/gcrb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module gcrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> design/greedy_capacitated_route_builder.sv
// Top level: load stores, then build capacity-limited routes by the nearest-neighbor rule.
// Load requests are accepted one per cycle while the block is idle.
// A start request walks the stores: each list entry tried passes ST_NB_RD, ST_NB_W
// and ST_NB_CHK; each node in a distance scan passes ST_D_RD and ST_D_CHK.
// Result rate is set by the walk over the single-read-port RAMs and by route back-pressure.
// Reset clears control state and list lengths, presets config; RAM contents are undefined.
`default_nettype none
module greedy_capacitated_route_builder #(
	parameter int MAX_NODES      = gcrb_pkg::DEF_MAX_NODES,
	parameter int MAX_VEHICLES   = gcrb_pkg::DEF_MAX_VEHICLES,
	parameter int NEIGHBOR_SLOTS = gcrb_pkg::DEF_NEIGHBOR_SLOTS,
	parameter int DIST_BITS      = gcrb_pkg::DEF_DIST_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	gcrb_cmd_if.sink                               cmd,
	gcrb_route_if.source                           route,
	input  wire logic                              cfg_we,
	input  wire logic [gcrb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gcrb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int NW  = $clog2(MAX_NODES);
	localparam int VIW = MAX_VEHICLES > 1 ? $clog2(MAX_VEHICLES) : 1;
	localparam int LW  = $clog2(NEIGHBOR_SLOTS + 1);
	localparam int NAW = (MAX_NODES * NEIGHBOR_SLOTS) > 1 ?
		$clog2(MAX_NODES * NEIGHBOR_SLOTS) : 1;
	localparam int DAW = $clog2(MAX_NODES * MAX_NODES);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_VSTART = 4'd1;
	localparam logic [3:0] ST_LEN    = 4'd2;
	localparam logic [3:0] ST_LENW   = 4'd3;
	localparam logic [3:0] ST_NB_RD  = 4'd4;
	localparam logic [3:0] ST_NB_W   = 4'd5;
	localparam logic [3:0] ST_NB_CHK = 4'd6;
	localparam logic [3:0] ST_D_RD   = 4'd7;
	localparam logic [3:0] ST_D_CHK  = 4'd8;
	localparam logic [3:0] ST_EMIT   = 4'd9;
	localparam logic [3:0] ST_NEXTV  = 4'd10;
	localparam logic [3:0] ST_MARK   = 4'd11;

	logic [3:0]                        st_q;
	logic [gcrb_pkg::VCOUNT_W-1:0]     vcount_q;
	logic [gcrb_pkg::NCOUNT_W-1:0]     ncount_q;
	logic [gcrb_pkg::VCOUNT_W-1:0]     vehs_q;
	logic [NW:0]                       nodes_q;
	logic [VIW-1:0]                    veh_q;
	logic [NW-1:0]                     cur_q;
	logic [gcrb_pkg::CAP_W-1:0]        load_q;
	logic [gcrb_pkg::CAP_W-1:0]        cap_q;
	logic [LW-1:0]                     len_q;
	logic [LW-1:0]                     i_q;
	logic [NW:0]                       j_q;
	logic [gcrb_pkg::NB_ID_W-1:0]      nb_q;
	logic [NW-1:0]                     pick_q;
	logic [gcrb_pkg::DEMAND_W-1:0]     pick_dem_q;
	logic [DIST_BITS-1:0]              best_q;
	logic                              found_q;
	logic [MAX_NODES-1:0]              visited_q;
	logic [MAX_NODES-1:0]              len_valid_q;
	logic [gcrb_pkg::CAP_W-1:0]        cap_store_q [MAX_VEHICLES];

	logic                              out_valid_q;
	logic [gcrb_pkg::VEHICLE_W-1:0]    out_vehicle_q;
	logic [gcrb_pkg::INDEX_W-1:0]      out_client_q;
	logic                              out_assign_q;
	logic                              out_last_q;

	logic                              cmd_fire;
	logic                              row_node_ok;
	logic                              slot_free;
	logic                              emit_now;
	logic [gcrb_pkg::VCOUNT_W-1:0]     vehs_clamp;
	logic [NW:0]                       nodes_clamp;
	logic [LW-1:0]                     len_sat;

	logic                              dem_we;
	logic [NW-1:0]                     dem_raddr;
	logic [gcrb_pkg::DEMAND_W-1:0]     dem_rdata;
	logic                              dist_we;
	logic [DAW-1:0]                    dist_waddr;
	logic [DAW-1:0]                    dist_raddr;
	logic [DIST_BITS-1:0]              dist_rdata;
	logic                              nb_we;
	logic [NAW-1:0]                    nb_waddr;
	logic [NAW-1:0]                    nb_raddr;
	logic [gcrb_pkg::NB_ID_W-1:0]      nb_rdata;
	logic                              len_we;
	logic [LW-1:0]                     len_rdata;

	logic                              cand_fits;
	logic                              nb_fits;
	logic [gcrb_pkg::CAP_W:0]          load_sum;

	assign cmd_fire    = cmd.valid && cmd.ready;
	assign cmd.ready   = (st_q == ST_IDLE);
	assign row_node_ok = 32'(cmd.row_index) < MAX_NODES;
	assign slot_free   = !out_valid_q || route.ready;
	assign emit_now    = slot_free && (st_q == ST_EMIT || st_q == ST_MARK);

	assign vehs_clamp  = (32'(vcount_q) > MAX_VEHICLES) ?
		gcrb_pkg::VCOUNT_W'(MAX_VEHICLES) : vcount_q;
	assign nodes_clamp = (32'(ncount_q) > MAX_NODES) ? (NW+1)'(MAX_NODES) : (NW+1)'(ncount_q);
	assign len_sat     = (32'(cmd.load_value) > NEIGHBOR_SLOTS) ?
		LW'(NEIGHBOR_SLOTS) : LW'(cmd.load_value);

	assign dem_we  = cmd_fire && cmd.opcode == gcrb_pkg::OP_DEMAND && row_node_ok;
	assign dist_we = cmd_fire && cmd.opcode == gcrb_pkg::OP_DISTANCE && row_node_ok &&
		32'(cmd.col_index) < MAX_NODES;
	assign nb_we   = cmd_fire && cmd.opcode == gcrb_pkg::OP_NB_ENTRY && row_node_ok &&
		32'(cmd.col_index) < NEIGHBOR_SLOTS;
	assign len_we  = cmd_fire && cmd.opcode == gcrb_pkg::OP_NB_COUNT && row_node_ok;

	assign dist_waddr = DAW'(cmd.row_index) * DAW'(MAX_NODES) + DAW'(cmd.col_index);
	assign nb_waddr   = NAW'(cmd.row_index) * NAW'(NEIGHBOR_SLOTS) + NAW'(cmd.col_index);
	assign dist_raddr = DAW'(cur_q) * DAW'(MAX_NODES) + DAW'(j_q[NW-1:0]);
	assign nb_raddr   = NAW'(cur_q) * NAW'(NEIGHBOR_SLOTS) + NAW'(i_q);
	assign dem_raddr  = (st_q == ST_NB_W) ? NW'(nb_rdata) : j_q[NW-1:0];

	assign load_sum  = {1'b0, load_q} + (gcrb_pkg::CAP_W+1)'(dem_rdata);
	assign cand_fits = !visited_q[j_q[NW-1:0]] && load_sum <= {1'b0, cap_q};
	assign nb_fits   = (32'(nb_q) < 32'(nodes_q)) && !visited_q[NW'(nb_q)] &&
		load_sum <= {1'b0, cap_q};

	gcrb_ram #(.WIDTH(gcrb_pkg::DEMAND_W), .DEPTH(MAX_NODES)) u_demand (
		.clk(clk), .we(dem_we), .waddr(NW'(cmd.row_index)),
		.wdata(cmd.load_value[gcrb_pkg::DEMAND_W-1:0]), .raddr(dem_raddr), .rdata(dem_rdata)
	);

	gcrb_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_distance (
		.clk(clk), .we(dist_we), .waddr(dist_waddr),
		.wdata(DIST_BITS'(cmd.load_value)), .raddr(dist_raddr), .rdata(dist_rdata)
	);

	gcrb_ram #(.WIDTH(gcrb_pkg::NB_ID_W), .DEPTH(MAX_NODES * NEIGHBOR_SLOTS)) u_neighbor (
		.clk(clk), .we(nb_we), .waddr(nb_waddr),
		.wdata(cmd.load_value[gcrb_pkg::NB_ID_W-1:0]), .raddr(nb_raddr), .rdata(nb_rdata)
	);

	gcrb_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_length (
		.clk(clk), .we(len_we), .waddr(NW'(cmd.row_index)),
		.wdata(len_sat), .raddr(cur_q), .rdata(len_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.opcode == gcrb_pkg::OP_CAPACITY &&
			32'(cmd.row_index) < MAX_VEHICLES) begin
			cap_store_q[VIW'(cmd.row_index)] <= cmd.load_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= gcrb_pkg::VCOUNT_W'(1);
			ncount_q <= gcrb_pkg::NCOUNT_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcrb_pkg::REG_VEHICLE_COUNT: vcount_q <= cfg_data[gcrb_pkg::VCOUNT_W-1:0];
				gcrb_pkg::REG_NODE_COUNT:    ncount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_valid_q <= '0;
		end else if (len_we) begin
			len_valid_q[NW'(cmd.row_index)] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			visited_q    <= MAX_NODES'(1);
			load_q       <= '0;
			cur_q        <= '0;
			veh_q        <= '0;
			vehs_q       <= '0;
			nodes_q      <= '0;
			cap_q        <= '0;
			len_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			nb_q         <= '0;
			pick_q       <= '0;
			pick_dem_q   <= '0;
			best_q       <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_vehicle_q <= '0;
			out_client_q <= '0;
			out_assign_q <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (route.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_fire && cmd.opcode == gcrb_pkg::OP_START) begin
						visited_q <= MAX_NODES'(1);
						veh_q     <= '0;
						vehs_q    <= vehs_clamp;
						nodes_q   <= nodes_clamp;
						if (vehs_clamp == '0 || nodes_clamp <= (NW+1)'(1)) begin
							st_q <= ST_MARK;
						end else begin
							st_q <= ST_VSTART;
						end
					end
				end
				ST_VSTART: begin
					cap_q  <= cap_store_q[veh_q];
					cur_q  <= '0;
					load_q <= '0;
					st_q   <= ST_LEN;
				end
				ST_LEN: begin
					st_q <= ST_LENW;
				end
				ST_LENW: begin
					len_q <= len_valid_q[cur_q] ? len_rdata : '0;
					i_q   <= '0;
					st_q  <= ST_NB_RD;
				end
				ST_NB_RD: begin
					if (i_q == len_q) begin
						j_q     <= (NW+1)'(1);
						found_q <= 1'b0;
						st_q    <= ST_D_RD;
					end else begin
						st_q <= ST_NB_W;
					end
				end
				ST_NB_W: begin
					nb_q <= nb_rdata;
					st_q <= ST_NB_CHK;
				end
				ST_NB_CHK: begin
					if (nb_fits) begin
						pick_q     <= NW'(nb_q);
						pick_dem_q <= dem_rdata;
						st_q       <= ST_EMIT;
					end else begin
						i_q  <= i_q + LW'(1);
						st_q <= ST_NB_RD;
					end
				end
				ST_D_RD: begin
					if (j_q == nodes_q) begin
						st_q <= found_q ? ST_EMIT : ST_NEXTV;
					end else begin
						st_q <= ST_D_CHK;
					end
				end
				ST_D_CHK: begin
					if (cand_fits && (!found_q || dist_rdata < best_q)) begin
						best_q     <= dist_rdata;
						pick_q     <= j_q[NW-1:0];
						pick_dem_q <= dem_rdata;
						found_q    <= 1'b1;
					end
					j_q  <= j_q + (NW+1)'(1);
					st_q <= ST_D_RD;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_vehicle_q     <= gcrb_pkg::VEHICLE_W'(veh_q);
						out_client_q      <= gcrb_pkg::INDEX_W'(pick_q);
						out_assign_q      <= 1'b1;
						out_last_q        <= 1'b0;
						visited_q[pick_q] <= 1'b1;
						load_q            <= load_q + gcrb_pkg::CAP_W'(pick_dem_q);
						cur_q             <= pick_q;
						st_q              <= ST_LEN;
					end
				end
				ST_NEXTV: begin
					veh_q <= veh_q + VIW'(1);
					if (32'(veh_q) + 1 == 32'(vehs_q)) begin
						st_q <= ST_MARK;
					end else begin
						st_q <= ST_VSTART;
					end
				end
				ST_MARK: begin
					if (slot_free) begin
						out_vehicle_q <= '0;
						out_client_q  <= '0;
						out_assign_q  <= 1'b0;
						out_last_q    <= 1'b1;
						st_q          <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign route.valid         = out_valid_q;
	assign route.vehicle       = out_vehicle_q;
	assign route.client        = out_client_q;
	assign route.is_assignment = out_assign_q;
	assign route.last          = out_last_q;

`ifndef SYNTHESIS
	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_assign_q != out_last_q))
		else $error("result is neither assignment nor marker exclusively");

	a_pick_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && slot_free) |-> !visited_q[pick_q])
		else $error("client assigned twice in one run");

	a_load_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_NB_RD) |-> (load_q <= cap_q))
		else $error("route load exceeds vehicle capacity");
`endif
endmodule
`default_nettype wire

>>> tb/tb_greedy_capacitated_route_builder.sv
// Self-checking testbench for the greedy capacitated route builder.
module tb_greedy_capacitated_route_builder;
	localparam int NODES     = gcrb_pkg::DEF_MAX_NODES;
	localparam int VEHICLES  = gcrb_pkg::DEF_MAX_VEHICLES;
	localparam int SLOTS     = gcrb_pkg::DEF_NEIGHBOR_SLOTS;
	localparam int DIST_W    = gcrb_pkg::DEF_DIST_BITS;
	localparam int SPAN      = 4;
	localparam int RUN_LIMIT = 200000;

	localparam logic [gcrb_pkg::OPCODE_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [gcrb_pkg::OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [gcrb_pkg::VEHICLE_W-1:0] vehicle;
		logic [gcrb_pkg::INDEX_W-1:0]   client;
		logic                           is_assignment;
		logic                           last;
	} route_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [gcrb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gcrb_pkg::CFG_DATA_W-1:0] cfg_data;

	gcrb_cmd_if   cmd_ch ();
	gcrb_route_if route_ch ();

	greedy_capacitated_route_builder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch.sink),
		.route     (route_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block state.
	logic [gcrb_pkg::DEMAND_W-1:0] demand_mem [NODES];
	logic [gcrb_pkg::CAP_W-1:0]    capacity_mem [VEHICLES];
	logic [DIST_W-1:0]             distance_mem [NODES*NODES];
	logic [gcrb_pkg::NB_ID_W-1:0]  neighbor_mem [NODES*SLOTS];
	int                            neighbor_len [NODES];
	int                            vehicle_limit;
	int                            node_limit;

	route_item_t expected_routes [$];
	int  error_count;
	int  cycle_count;
	int  requests_sent;
	int  routes_checked;
	int  starts_sent;
	int  resp_stall;
	bit  calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// Greedy route construction over the shadow stores.
	function automatic void predict_routes();
		bit seen [NODES];
		int nodes, vehs, cur, pick, best, d, nb;
		longint used, cap;
		bit found;
		route_item_t item;
		nodes = node_limit > NODES ? NODES : node_limit;
		vehs = vehicle_limit > VEHICLES ? VEHICLES : vehicle_limit;
		foreach (seen[i])
			seen[i] = 1'b0;
		seen[0] = 1'b1;
		for (int v = 0; v < vehs; v++) begin
			cap = capacity_mem[v];
			cur = 0;
			used = 0;
			forever begin
				found = 1'b0;
				pick = 0;
				for (int i = 0; i < neighbor_len[cur]; i++) begin
					nb = neighbor_mem[cur*SLOTS+i];
					if (nb < nodes && !seen[nb] && used + demand_mem[nb] <= cap) begin
						pick = nb;
						found = 1'b1;
						break;
					end
				end
				if (!found) begin
					best = 0;
					for (int i = 1; i < nodes; i++) begin
						if (!seen[i] && used + demand_mem[i] <= cap) begin
							d = distance_mem[cur*NODES+i];
							if (!found || d < best) begin
								best = d;
								pick = i;
								found = 1'b1;
							end
						end
					end
				end
				if (!found)
					break;
				item.vehicle = gcrb_pkg::VEHICLE_W'(v);
				item.client = gcrb_pkg::INDEX_W'(pick);
				item.is_assignment = 1'b1;
				item.last = 1'b0;
				expected_routes.push_back(item);
				seen[pick] = 1'b1;
				used += demand_mem[pick];
				cur = pick;
			end
		end
		item = '0;
		item.last = 1'b1;
		expected_routes.push_back(item);
	endfunction

	function automatic void apply_request(input logic [gcrb_pkg::OPCODE_W-1:0] op,
			input int row, input int col, input logic [gcrb_pkg::VALUE_W-1:0] val);
		case (op)
			gcrb_pkg::OP_DEMAND: demand_mem[row] = val[gcrb_pkg::DEMAND_W-1:0];
			gcrb_pkg::OP_CAPACITY: if (row < VEHICLES) capacity_mem[row] = val;
			gcrb_pkg::OP_DISTANCE: distance_mem[row*NODES+col] = val[DIST_W-1:0];
			gcrb_pkg::OP_NB_ENTRY:
				if (col < SLOTS) neighbor_mem[row*SLOTS+col] = val[gcrb_pkg::NB_ID_W-1:0];
			gcrb_pkg::OP_NB_COUNT: neighbor_len[row] = (int'(val) > SLOTS) ? SLOTS : int'(val);
			gcrb_pkg::OP_START: begin
				predict_routes();
				starts_sent++;
			end
			default: ;
		endcase
	endfunction

	task automatic send_request(input logic [gcrb_pkg::OPCODE_W-1:0] op, input int row,
			input int col, input logic [gcrb_pkg::VALUE_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.row_index <= gcrb_pkg::INDEX_W'(row);
		cmd_ch.col_index <= gcrb_pkg::INDEX_W'(col);
		cmd_ch.load_value <= val;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		apply_request(op, row, col, val);
		requests_sent++;
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_routes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_config(input logic [gcrb_pkg::CFG_IDX_W-1:0] idx, input int val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= gcrb_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == gcrb_pkg::REG_VEHICLE_COUNT)
			vehicle_limit = val & 'hF;
		else
			node_limit = val & 'h7F;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		route_item_t want;
		if (!arst_n) begin
			route_ch.ready <= 1'b0;
			resp_stall = 0;
		end else begin
			if (route_ch.valid && route_ch.ready) begin
				if (expected_routes.size() == 0) begin
					report_mismatch("unexpected route item", route_ch.client, -1);
				end else begin
					want = expected_routes.pop_front();
					if (route_ch.vehicle !== want.vehicle)
						report_mismatch("vehicle", route_ch.vehicle, want.vehicle);
					if (route_ch.client !== want.client)
						report_mismatch("client", route_ch.client, want.client);
					if (route_ch.is_assignment !== want.is_assignment)
						report_mismatch("is_assignment", route_ch.is_assignment,
							want.is_assignment);
					if (route_ch.last !== want.last)
						report_mismatch("last", route_ch.last, want.last);
					routes_checked++;
				end
			end
			if (resp_stall > 0) begin
				route_ch.ready <= 1'b0;
				resp_stall--;
			end else begin
				route_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					resp_stall = pick_gap();
			end
		end
	end

	// Every entry that a route build over the first SPAN nodes can read is written here.
	task automatic test_fill_stores();
		write_config(gcrb_pkg::REG_NODE_COUNT, SPAN);
		calm = 1'b1;
		for (int i = 0; i < SPAN; i++)
			send_request(gcrb_pkg::OP_DEMAND, i, 0, 20'($urandom_range(1, 20)));
		for (int i = 0; i < VEHICLES; i++)
			send_request(gcrb_pkg::OP_CAPACITY, i, 0, 20'($urandom_range(5, 40)));
		for (int r = 0; r < SPAN; r++)
			for (int c = 0; c < SPAN; c++)
				send_request(gcrb_pkg::OP_DISTANCE, r, c, 20'($urandom_range(0, 15)));
		for (int r = 0; r < SPAN; r++) begin
			for (int s = 0; s < SLOTS; s++)
				send_request(gcrb_pkg::OP_NB_ENTRY, r, s, 20'($urandom_range(0, 63)));
			send_request(gcrb_pkg::OP_NB_COUNT, r, 0, 20'($urandom_range(0, 12)));
		end
		calm = 1'b0;
	endtask

	task automatic test_marker_only();
		write_config(gcrb_pkg::REG_VEHICLE_COUNT, 0);
		send_request(gcrb_pkg::OP_START, 0, 0, 0);
		write_config(gcrb_pkg::REG_VEHICLE_COUNT, 3);
		write_config(gcrb_pkg::REG_NODE_COUNT, 0);
		send_request(gcrb_pkg::OP_START, 0, 0, 0);
		write_config(gcrb_pkg::REG_NODE_COUNT, 1);
		send_request(gcrb_pkg::OP_START, 0, 0, 0);
	endtask

	task automatic test_directed_routes();
		write_config(gcrb_pkg::REG_NODE_COUNT, 2);
		send_request(gcrb_pkg::OP_START, 0, 0, 0);
		write_config(gcrb_pkg::REG_NODE_COUNT, SPAN);
		write_config(gcrb_pkg::REG_VEHICLE_COUNT, 15);
		send_request(gcrb_pkg::OP_DEMAND, 2, 0, 20'hFFFFF);
		send_request(gcrb_pkg::OP_CAPACITY, 0, 0, 20'h00000);
		send_request(gcrb_pkg::OP_CAPACITY, 1, 0, 20'hFFFFF);
		send_request(gcrb_pkg::OP_CAPACITY, 9, 0, 20'h12345);
		send_request(gcrb_pkg::OP_NB_ENTRY, 0, 9, 3);
		send_request(gcrb_pkg::OP_NB_ENTRY, 0, 0, 63);
		send_request(gcrb_pkg::OP_NB_COUNT, 0, 0, 20'hFFFFF);
		send_request(gcrb_pkg::OP_DISTANCE, 1, 3, 20'hFFFFF);
		send_request(OP_UNUSED_LO, 63, 63, 20'hFFFFF);
		send_request(OP_UNUSED_HI, 0, 0, 0);
		send_request(gcrb_pkg::OP_START, 0, 0, 0);
		send_request(gcrb_pkg::OP_START, 0, 0, 0);
		wait_idle();
		write_config(gcrb_pkg::REG_NODE_COUNT, 3);
		send_request(gcrb_pkg::OP_START, 0, 0, 0);
	endtask

	task automatic test_random_traffic();
		int row, col, r;
		logic [gcrb_pkg::OPCODE_W-1:0] op;
		logic [gcrb_pkg::VALUE_W-1:0] val;
		for (int n = 0; n < 40; n++) begin
			if (n % 10 == 0) begin
				write_config(gcrb_pkg::REG_VEHICLE_COUNT, $urandom_range(0, 15));
				write_config(gcrb_pkg::REG_NODE_COUNT, $urandom_range(0, SPAN));
				calm = (n == 20);
			end
			r = $urandom_range(0, 99);
			row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
				$urandom_range(0, SPAN - 1);
			col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
				$urandom_range(0, SPAN - 1);
			val = 20'($urandom_range(0, 20'hFFFFF));
			if (r < 15) begin
				op = gcrb_pkg::OP_START;
			end else if (r < 32) begin
				op = gcrb_pkg::OP_DEMAND;
				if (r < 29)
					val = 20'($urandom_range(0, 30));
			end else if (r < 44) begin
				op = gcrb_pkg::OP_CAPACITY;
				row = $urandom_range(0, 9);
				if (r < 40)
					val = 20'($urandom_range(0, 60));
			end else if (r < 65) begin
				op = gcrb_pkg::OP_DISTANCE;
				if (r < 60)
					val = 20'($urandom_range(0, 40));
			end else if (r < 80) begin
				op = gcrb_pkg::OP_NB_ENTRY;
				col = $urandom_range(0, SLOTS + 1);
				val = 20'($urandom_range(0, SPAN + 1));
			end else if (r < 95) begin
				op = gcrb_pkg::OP_NB_COUNT;
				if (r < 92)
					val = 20'($urandom_range(0, 12));
			end else begin
				op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
			end
			send_request(op, row, col, val);
		end
		calm = 1'b0;
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		requests_sent = 0;
		routes_checked = 0;
		starts_sent = 0;
		calm = 1'b0;
		vehicle_limit = 1;
		node_limit = 64;
		foreach (neighbor_len[i])
			neighbor_len[i] = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = '0;
		cmd_ch.row_index = '0;
		cmd_ch.col_index = '0;
		cmd_ch.load_value = '0;
		route_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_stores();
		send_request(gcrb_pkg::OP_START, 0, 0, 0);
		test_marker_only();
		test_directed_routes();
		test_random_traffic();
		wait_idle();
		repeat (100) @(posedge clk);
		$display("Sent %0d requests including %0d starts; checked %0d route items.",
			requests_sent, starts_sent, routes_checked);
		$display("Exercised empty runs, clamped vehicle counts, full lists and random loads.");
		if (error_count == 0 && expected_routes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d route items missing", error_count,
				expected_routes.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

>>> files.f
design/gcrb_pkg.sv
design/gcrb_if.sv
design/gcrb_ram.sv
design/greedy_capacitated_route_builder.sv
tb/tb_greedy_capacitated_route_builder.sv
